// ----- rtl/core/tsjw_pkg.sv -----
// Shared types and constants of the join/wait thread scheduler.
`default_nettype none
package tsjw_pkg;

   localparam int ID_W    = 4;
   localparam int NUM_IDS = 16;
   localparam int CNT_W   = 5;
   localparam int VAL_W   = 32;

   typedef enum logic [2:0] {
      CMD_ADD     = 3'd0,
      CMD_YIELD   = 3'd1,
      CMD_SUSPEND = 3'd2,
      CMD_FINISH  = 3'd3,
      CMD_KILL    = 3'd4,
      CMD_WAKE    = 3'd5,
      CMD_REMOVE  = 3'd6,
      CMD_QUERY   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      TS_ABSENT    = 3'd0,
      TS_READY     = 3'd1,
      TS_RUNNING   = 3'd2,
      TS_SUSPENDED = 3'd3,
      TS_FINISHED  = 3'd4
   } tstate_type;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_EXITED  = 2'd2;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   target;
      logic              target_valid;
      logic              want_result;
      logic [VAL_W-1:0]  exit_value_in;
      logic [ID_W-1:0]   switch_target;
      logic              switch_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   running_thread;
      logic              running_valid;
      logic              target_finished;
      logic              target_killed;
      logic [ID_W-1:0]   woken_thread;
      logic [VAL_W-1:0]  delivered_value;
      logic              delivery_valid;
      logic              last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUSH_T,
      OP_PUSH_R,
      OP_SUSP_R,
      OP_FIN_MARK,
      OP_SCAN_RDY,
      OP_SCAN_SUS,
      OP_SCAN_SW,
      OP_SCAN_NEXT,
      OP_WAKE_AT,
      OP_KILL_RM,
      OP_WAKE_RM,
      OP_REMOVE_RM,
      OP_ABSENT_FIN,
      OP_JOIN_LD,
      OP_POP,
      OP_SW_TAKE,
      OP_EMIT_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic [1:0]  status;
      logic        emit_deliv;
      logic        emit_final;
   } ctl_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        t_ok;
      tstate_type  ts;
      logic        sw_ready;
      logic        run_ok;
      logic        run_is_t;
      logic        target_valid;
      logic        want;
      logic        switch_valid;
      logic        scan_hit;
      logic        scan_end;
      logic        w_match;
      logic        w_end;
      logic        deliv_any;
      logic        emit_more;
   } dps_type;

endpackage
`default_nettype wire

// ----- rtl/core/tsjw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsjw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/tsjw_datapath.sv -----
// Scheduler datapath: thread table, ready and suspend lists, exit values, deliveries.
`default_nettype none
module tsjw_datapath #(
   parameter int MAX_THREADS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tsjw_pkg::req_type req_item,
   input  wire tsjw_pkg::ctl_type ctl,
   output tsjw_pkg::dps_type      dps,
   output tsjw_pkg::rsp_type      rsp_item
);
   import tsjw_pkg::*;

   typedef logic [ID_W-1:0] id_list_type [NUM_IDS];

   function automatic id_list_type list_drop_at(id_list_type l, logic [CNT_W-1:0] pos);
      id_list_type r;
      r = l;
      for (int k = 0; k < NUM_IDS - 1; k++) begin
         if (CNT_W'(k) >= pos) begin
            r[k] = l[k+1];
         end
      end
      return r;
   endfunction

   req_type          req_ff, req_in;
   tstate_type       ts_ff [NUM_IDS];
   tstate_type       ts_in [NUM_IDS];
   logic             jv_ff [NUM_IDS];
   logic             jv_in [NUM_IDS];
   logic [ID_W-1:0]  jt_ff [NUM_IDS];
   logic [ID_W-1:0]  jt_in [NUM_IDS];
   logic             jw_ff [NUM_IDS];
   logic             jw_in [NUM_IDS];
   logic             kill_ff [NUM_IDS];
   logic             kill_in [NUM_IDS];
   id_list_type      rdy_ff, rdy_in;
   id_list_type      sus_ff, sus_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [CNT_W-1:0] scnt_ff, scnt_in;
   logic [ID_W-1:0]  run_ff, run_in;
   logic             run_ok_ff, run_ok_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             sel_sus_ff, sel_sus_in;
   logic [ID_W-1:0]  key_ff, key_in;
   logic [ID_W-1:0]  fin_ff, fin_in;
   logic [VAL_W-1:0] dval_ff, dval_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CNT_W-1:0] emit_ff, emit_in;

   logic [ID_W-1:0]  t, sw, w, list_at, fin_id, dram_wdata, dram_rd;
   logic [VAL_W-1:0] fin_val, xram_rd;
   logic [CNT_W-1:0] list_cnt;
   logic             t_ok, sw_ok, scan_end, scan_hit, w_end, w_match, dram_we, is_query;

   assign t        = req_ff.target;
   assign sw       = req_ff.switch_target;
   assign t_ok     = (32'(t) < 32'(MAX_THREADS));
   assign sw_ok    = (32'(sw) < 32'(MAX_THREADS));
   assign list_cnt = sel_sus_ff ? scnt_ff : rcnt_ff;
   assign list_at  = sel_sus_ff ? sus_ff[scan_ff[ID_W-1:0]] : rdy_ff[scan_ff[ID_W-1:0]];
   assign scan_end = (scan_ff >= list_cnt);
   assign scan_hit = !scan_end && (list_at == key_ff);
   assign w        = sus_ff[scan_ff[ID_W-1:0]];
   assign w_end    = (scan_ff >= scnt_ff);
   assign w_match  = !w_end && jv_ff[w] && (jt_ff[w] == fin_ff);
   assign fin_id   = (req_ff.cmd == CMD_FINISH) ? run_ff : t;
   assign fin_val  = (req_ff.cmd == CMD_FINISH) ? req_ff.exit_value_in : '0;
   assign is_query = (req_ff.cmd == CMD_QUERY) && t_ok;

   assign dram_we    = ((ctl.op == OP_WAKE_AT) && jw_ff[w]) || (ctl.op == OP_JOIN_LD);
   assign dram_wdata = (ctl.op == OP_JOIN_LD) ? run_ff : w;

   tsjw_ram #(.WIDTH(VAL_W), .DEPTH(NUM_IDS)) u_exit_ram (
      .clock   (clock),
      .wr_en   (ctl.op == OP_FIN_MARK),
      .wr_addr (fin_id),
      .wr_data (fin_val),
      .rd_addr (t),
      .rd_data (xram_rd)
   );

   tsjw_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_deliv_ram (
      .clock   (clock),
      .wr_en   (dram_we),
      .wr_addr (dcnt_ff[ID_W-1:0]),
      .wr_data (dram_wdata),
      .rd_addr (emit_ff[ID_W-1:0]),
      .rd_data (dram_rd)
   );

   always_comb begin
      req_in     = req_ff;
      ts_in      = ts_ff;
      jv_in      = jv_ff;
      jt_in      = jt_ff;
      jw_in      = jw_ff;
      kill_in    = kill_ff;
      rdy_in     = rdy_ff;
      sus_in     = sus_ff;
      rcnt_in    = rcnt_ff;
      scnt_in    = scnt_ff;
      run_in     = run_ff;
      run_ok_in  = run_ok_ff;
      scan_in    = scan_ff;
      sel_sus_in = sel_sus_ff;
      key_in     = key_ff;
      fin_in     = fin_ff;
      dval_in    = dval_ff;
      dcnt_in    = dcnt_ff;
      emit_in    = emit_ff;
      unique case (ctl.op)
         OP_NONE: begin
         end
         OP_LATCH: begin
            req_in  = req_item;
            dcnt_in = '0;
            emit_in = '0;
         end
         OP_PUSH_T: begin
            rdy_in[rcnt_ff[ID_W-1:0]] = t;
            rcnt_in   = rcnt_ff + 1'b1;
            ts_in[t]  = TS_READY;
         end
         OP_PUSH_R: begin
            rdy_in[rcnt_ff[ID_W-1:0]] = run_ff;
            rcnt_in       = rcnt_ff + 1'b1;
            ts_in[run_ff] = TS_READY;
            run_ok_in     = 1'b0;
         end
         OP_SUSP_R: begin
            ts_in[run_ff] = TS_SUSPENDED;
            jv_in[run_ff] = req_ff.target_valid;
            jt_in[run_ff] = t;
            jw_in[run_ff] = req_ff.target_valid && req_ff.want_result;
            sus_in[scnt_ff[ID_W-1:0]] = run_ff;
            scnt_in       = scnt_ff + 1'b1;
            run_ok_in     = 1'b0;
         end
         OP_FIN_MARK: begin
            ts_in[fin_id]   = TS_FINISHED;
            kill_in[fin_id] = (req_ff.cmd == CMD_KILL);
            dval_in         = fin_val;
            fin_in          = fin_id;
            scan_in         = '0;
            if (run_ok_ff && (run_ff == fin_id)) begin
               run_ok_in = 1'b0;
            end
         end
         OP_SCAN_RDY: begin
            scan_in    = '0;
            sel_sus_in = 1'b0;
            key_in     = t;
         end
         OP_SCAN_SUS: begin
            scan_in    = '0;
            sel_sus_in = 1'b1;
            key_in     = t;
         end
         OP_SCAN_SW: begin
            scan_in    = '0;
            sel_sus_in = 1'b0;
            key_in     = sw;
         end
         OP_SCAN_NEXT: begin
            scan_in = scan_ff + 1'b1;
         end
         OP_WAKE_AT: begin
            // scan index stays: the next waiter shifts into this slot
            sus_in   = list_drop_at(sus_ff, scan_ff);
            scnt_in  = scnt_ff - 1'b1;
            jv_in[w] = 1'b0;
            jw_in[w] = 1'b0;
            rdy_in[rcnt_ff[ID_W-1:0]] = w;
            rcnt_in  = rcnt_ff + 1'b1;
            ts_in[w] = TS_READY;
            if (jw_ff[w]) begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         OP_KILL_RM, OP_REMOVE_RM: begin
            if (sel_sus_ff) begin
               sus_in  = list_drop_at(sus_ff, scan_ff);
               scnt_in = scnt_ff - 1'b1;
            end else begin
               rdy_in  = list_drop_at(rdy_ff, scan_ff);
               rcnt_in = rcnt_ff - 1'b1;
            end
            jv_in[t] = 1'b0;
            jw_in[t] = 1'b0;
            if (ctl.op == OP_REMOVE_RM) begin
               ts_in[t] = TS_ABSENT;
            end
         end
         OP_WAKE_RM: begin
            sus_in   = list_drop_at(sus_ff, scan_ff);
            scnt_in  = scnt_ff - 1'b1;
            jv_in[t] = 1'b0;
            jw_in[t] = 1'b0;
            rdy_in[rcnt_ff[ID_W-1:0]] = t;
            rcnt_in  = rcnt_ff + 1'b1;
            ts_in[t] = TS_READY;
         end
         OP_ABSENT_FIN: begin
            ts_in[t]   = TS_ABSENT;
            kill_in[t] = 1'b0;
         end
         OP_JOIN_LD: begin
            dval_in = xram_rd;
            dcnt_in = dcnt_ff + 1'b1;
         end
         OP_POP: begin
            if (rcnt_ff != '0) begin
               run_in           = rdy_ff[0];
               run_ok_in        = 1'b1;
               ts_in[rdy_ff[0]] = TS_RUNNING;
               rdy_in           = list_drop_at(rdy_ff, '0);
               rcnt_in          = rcnt_ff - 1'b1;
            end else begin
               run_in    = '0;
               run_ok_in = 1'b0;
            end
         end
         OP_SW_TAKE: begin
            if (scan_hit) begin
               rdy_in  = list_drop_at(rdy_ff, scan_ff);
               rcnt_in = rcnt_ff - 1'b1;
            end
            run_in    = sw;
            run_ok_in = 1'b1;
            ts_in[sw] = TS_RUNNING;
         end
         OP_EMIT_NEXT: begin
            emit_in = emit_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_IDS; i++) begin
            ts_ff[i]   <= TS_ABSENT;
            jv_ff[i]   <= 1'b0;
            jw_ff[i]   <= 1'b0;
            kill_ff[i] <= 1'b0;
         end
         rcnt_ff   <= '0;
         scnt_ff   <= '0;
         run_ff    <= '0;
         run_ok_ff <= 1'b0;
         dcnt_ff   <= '0;
         emit_ff   <= '0;
      end else begin
         ts_ff     <= ts_in;
         jv_ff     <= jv_in;
         jw_ff     <= jw_in;
         kill_ff   <= kill_in;
         rcnt_ff   <= rcnt_in;
         scnt_ff   <= scnt_in;
         run_ff    <= run_in;
         run_ok_ff <= run_ok_in;
         dcnt_ff   <= dcnt_in;
         emit_ff   <= emit_in;
      end
      req_ff     <= req_in;
      jt_ff      <= jt_in;
      rdy_ff     <= rdy_in;
      sus_ff     <= sus_in;
      scan_ff    <= scan_in;
      sel_sus_ff <= sel_sus_in;
      key_ff     <= key_in;
      fin_ff     <= fin_in;
      dval_ff    <= dval_in;
   end

   always_comb begin
      dps.cmd          = req_ff.cmd;
      dps.t_ok         = t_ok;
      dps.ts           = ts_ff[t];
      dps.sw_ready     = sw_ok && (ts_ff[sw] == TS_READY);
      dps.run_ok       = run_ok_ff;
      dps.run_is_t     = (run_ff == t);
      dps.target_valid = req_ff.target_valid;
      dps.want         = req_ff.want_result;
      dps.switch_valid = req_ff.switch_valid;
      dps.scan_hit     = scan_hit;
      dps.scan_end     = scan_end;
      dps.w_match      = w_match;
      dps.w_end        = w_end;
      dps.deliv_any    = (dcnt_ff != '0);
      dps.emit_more    = ((emit_ff + 1'b1) < dcnt_ff);
   end

   always_comb begin
      rsp_item.status          = ctl.emit_final ? ctl.status : STS_OK;
      rsp_item.running_thread  = run_ok_ff ? run_ff : '0;
      rsp_item.running_valid   = run_ok_ff;
      rsp_item.target_finished = ctl.emit_final && is_query && (ts_ff[t] == TS_FINISHED);
      rsp_item.target_killed   = ctl.emit_final && is_query && (ts_ff[t] == TS_FINISHED)
                                 && kill_ff[t];
      rsp_item.woken_thread    = ctl.emit_deliv ? dram_rd : '0;
      rsp_item.delivered_value = ctl.emit_deliv ? dval_ff : '0;
      rsp_item.delivery_valid  = ctl.emit_deliv;
      rsp_item.last            = ctl.emit_final;
   end

endmodule
`default_nettype wire

// ----- rtl/core/tsjw_ctrl.sv -----
// Scheduler controller: sequences one command through the datapath.
`default_nettype none
module tsjw_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tsjw_pkg::dps_type dps,
   output tsjw_pkg::ctl_type      ctl
);
   import tsjw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_JOIN_LD,
      S_FIND,
      S_FIN_MARK,
      S_WSCAN,
      S_DISPATCH,
      S_SW_SCAN,
      S_EMIT_RD,
      S_EMIT_OUT,
      S_FINAL
   } state_type;

   state_type  state_ff, state_in, post_state;
   logic [1:0] sts_ff, sts_in;
   logic       disp_ff, disp_in;
   logic       usesw_ff, usesw_in;
   logic       busy_ff, busy_in;

   assign busy       = busy_ff;
   assign post_state = dps.deliv_any ? S_EMIT_RD : S_FINAL;

   always_comb begin
      state_in       = state_ff;
      sts_in         = sts_ff;
      disp_in        = disp_ff;
      usesw_in       = usesw_ff;
      ctl.op         = OP_NONE;
      ctl.status     = sts_ff;
      ctl.emit_deliv = 1'b0;
      ctl.emit_final = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            sts_in   = STS_OK;
            disp_in  = 1'b0;
            usesw_in = 1'b0;
            state_in = S_FINAL;
            unique case (dps.cmd)
               CMD_ADD: begin
                  if (!dps.t_ok) sts_in = STS_INVALID;
                  else if (dps.ts == TS_FINISHED) sts_in = STS_EXITED;
                  else if (dps.ts != TS_ABSENT) sts_in = STS_INVALID;
                  else ctl.op = OP_PUSH_T;
               end
               CMD_YIELD, CMD_SUSPEND, CMD_FINISH: begin
                  usesw_in = dps.switch_valid;
                  disp_in  = 1'b1;
                  if (dps.cmd == CMD_SUSPEND && dps.target_valid && !dps.t_ok) begin
                     sts_in = STS_INVALID;
                  end else if (dps.cmd == CMD_SUSPEND && dps.target_valid
                               && dps.ts == TS_FINISHED) begin
                     // join on a finished thread: deliver if a running caller wants it, no state change
                     if (dps.run_ok && dps.want) state_in = S_JOIN_LD;
                  end else if (dps.switch_valid && !dps.sw_ready) begin
                     sts_in = STS_INVALID;
                  end else if (!dps.run_ok) begin
                     state_in = S_DISPATCH;
                  end else if (dps.cmd == CMD_YIELD) begin
                     ctl.op   = OP_PUSH_R;
                     state_in = S_DISPATCH;
                  end else if (dps.cmd == CMD_SUSPEND) begin
                     ctl.op   = OP_SUSP_R;
                     state_in = S_DISPATCH;
                  end else begin
                     state_in = S_FIN_MARK;
                  end
               end
               CMD_KILL: begin
                  if (!dps.t_ok) sts_in = STS_INVALID;
                  else if (dps.run_ok && dps.run_is_t) begin
                     disp_in  = 1'b1;
                     state_in = S_FIN_MARK;
                  end else if (dps.ts == TS_READY) begin
                     ctl.op   = OP_SCAN_RDY;
                     state_in = S_FIND;
                  end else if (dps.ts == TS_SUSPENDED) begin
                     ctl.op   = OP_SCAN_SUS;
                     state_in = S_FIND;
                  end else if (dps.ts == TS_FINISHED) sts_in = STS_EXITED;
                  else sts_in = STS_INVALID;
               end
               CMD_WAKE: begin
                  if (!dps.t_ok) sts_in = STS_INVALID;
                  else if (dps.run_ok && dps.run_is_t) sts_in = STS_OK;
                  else if (dps.ts == TS_FINISHED) sts_in = STS_EXITED;
                  else if (dps.ts == TS_READY) sts_in = STS_OK;
                  else if (dps.ts == TS_SUSPENDED) begin
                     ctl.op   = OP_SCAN_SUS;
                     state_in = S_FIND;
                  end else sts_in = STS_INVALID;
               end
               CMD_REMOVE: begin
                  if (!dps.t_ok) sts_in = STS_INVALID;
                  else if (dps.ts == TS_FINISHED) ctl.op = OP_ABSENT_FIN;
                  else if (dps.ts == TS_READY) begin
                     ctl.op   = OP_SCAN_RDY;
                     state_in = S_FIND;
                  end else if (dps.ts == TS_SUSPENDED) begin
                     ctl.op   = OP_SCAN_SUS;
                     state_in = S_FIND;
                  end else sts_in = STS_INVALID;
               end
               CMD_QUERY: begin
                  if (!dps.t_ok) sts_in = STS_INVALID;
               end
               default: begin
               end
            endcase
         end
         S_JOIN_LD: begin
            ctl.op   = OP_JOIN_LD;
            state_in = S_EMIT_RD;
         end
         S_FIND: begin
            priority if (dps.scan_hit) begin
               if (dps.cmd == CMD_KILL) begin
                  ctl.op   = OP_KILL_RM;
                  state_in = S_FIN_MARK;
               end else if (dps.cmd == CMD_WAKE) begin
                  ctl.op   = OP_WAKE_RM;
                  state_in = S_FINAL;
               end else begin
                  ctl.op   = OP_REMOVE_RM;
                  state_in = S_FINAL;
               end
            end else if (dps.scan_end) begin
               sts_in   = STS_INVALID;
               state_in = S_FINAL;
            end else begin
               ctl.op = OP_SCAN_NEXT;
            end
         end
         S_FIN_MARK: begin
            ctl.op   = OP_FIN_MARK;
            state_in = S_WSCAN;
         end
         S_WSCAN: begin
            priority if (dps.w_end) begin
               state_in = disp_ff ? S_DISPATCH : post_state;
            end else if (dps.w_match) begin
               ctl.op = OP_WAKE_AT;
            end else begin
               ctl.op = OP_SCAN_NEXT;
            end
         end
         S_DISPATCH: begin
            if (usesw_ff) begin
               ctl.op   = OP_SCAN_SW;
               state_in = S_SW_SCAN;
            end else begin
               ctl.op   = OP_POP;
               state_in = post_state;
            end
         end
         S_SW_SCAN: begin
            if (dps.scan_hit || dps.scan_end) begin
               ctl.op   = OP_SW_TAKE;
               state_in = post_state;
            end else begin
               ctl.op = OP_SCAN_NEXT;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            ctl.emit_deliv = 1'b1;
            ctl.op         = OP_EMIT_NEXT;
            state_in       = dps.emit_more ? S_EMIT_RD : S_FINAL;
         end
         S_FINAL: begin
            ctl.emit_final = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         sts_ff   <= STS_OK;
         disp_ff  <= 1'b0;
         usesw_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         sts_ff   <= sts_in;
         disp_ff  <= disp_in;
         usesw_ff <= usesw_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/thread_scheduler_join_wait.sv -----
// Top level of the round-robin thread scheduler with join and exit values.
//
// Usage: drive one command item on req_item and raise start; the item is
// taken at an edge where start is high and busy is low. busy stays high
// until the item's last result has been shown.
// Results come on rsp_item, one per cycle in which rsp_valid is high, and
// are taken at the end of that cycle; the receiver cannot hold them off.
// Each item gives zero or more delivery results (delivery_valid high) and
// then one final result with last high; running fields show the state
// after the item.
// Add, query and simple rejects go from decode straight to the final result.
// A list search steps one entry at a time (up to 16), the waiter scan
// visits each suspended entry, a dispatch pops the ready list or searches
// it for the switch target, and each delivery is read from the delivery
// RAM, then shown. The longest item is a kill of the tail of a full
// suspend list whose 15 other entries join on it and want its value. The
// next item can be taken in the cycle after the final result.
// Reset (synchronous, active high): all threads absent, lists empty, nothing
// running; exit values are undefined until a thread finishes.
`default_nettype none
module thread_scheduler_join_wait #(
   parameter int MAX_THREADS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tsjw_pkg::req_type req_item,
   output logic                   rsp_valid,
   output tsjw_pkg::rsp_type      rsp_item
);
   import tsjw_pkg::*;

   ctl_type ctl;
   dps_type dps;

   tsjw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .dps   (dps),
      .ctl   (ctl)
   );

   tsjw_datapath #(.MAX_THREADS(MAX_THREADS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .ctl      (ctl),
      .dps      (dps),
      .rsp_item (rsp_item)
   );

   assign rsp_valid = ctl.emit_deliv | ctl.emit_final;

endmodule
`default_nettype wire

// ----- rtl/core/tsjw_checker.sv -----
// Port-level checks of the scheduler and their bind to the top level.
`default_nettype none
module tsjw_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire tsjw_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire tsjw_pkg::rsp_type rsp_item
);
   import tsjw_pkg::*;

   logic unused_req;
   assign unused_req = ^req_item;

   a_deliv_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.delivery_valid |-> !rsp_item.last && rsp_item.status == STS_OK)
      else $error("delivery item marked last or with nonzero status");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |=> !busy)
      else $error("busy held after final item");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted item did not raise busy");

endmodule

bind thread_scheduler_join_wait tsjw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
